>>> rtl/clns_pkg.sv
// Shared types, command codes and strobe tables for the character LCD nibble sequencer.
// No dependencies; every other rtl file imports this package.
package clns_pkg;

   // Command codes on req_command
   localparam logic [2:0] CMD_INIT           = 3'd0;
   localparam logic [2:0] CMD_WRITE_CHAR     = 3'd1;
   localparam logic [2:0] CMD_CLEAR          = 3'd2;
   localparam logic [2:0] CMD_GOTO_TRACKED   = 3'd3;
   localparam logic [2:0] CMD_GOTO_UNTRACKED = 3'd4;
   localparam logic [2:0] CMD_CURSOR_ON      = 3'd5;
   localparam logic [2:0] CMD_CURSOR_OFF     = 3'd6;
   localparam logic [2:0] CMD_GLYPH_ROW      = 3'd7;

   // Configuration register indexes
   localparam logic [1:0] CSR_LINE0_BASE = 2'd0;
   localparam logic [1:0] CSR_LINE1_BASE = 2'd1;

   localparam logic [6:0] LINE0_BASE_RESET = 7'd0;
   localparam logic [6:0] LINE1_BASE_RESET = 7'd64;

   // Controller instruction bytes
   localparam logic [7:0] INSTR_FUNCTION_SET = 8'b0010_1000;
   localparam logic [7:0] INSTR_DISPLAY_OFF  = 8'b0000_1000;
   localparam logic [7:0] INSTR_CLEAR        = 8'b0000_0001;
   localparam logic [7:0] INSTR_CURSOR_LINE  = 8'b0000_1110;
   localparam logic [7:0] INSTR_ENTRY_MODE   = 8'b0000_0110;
   localparam logic [7:0] INSTR_CURSOR_BLOCK = 8'b0000_1111;
   localparam logic [7:0] INSTR_CURSOR_OFF   = 8'b0000_1100;
   localparam logic [7:0] INSTR_HOME_ADDR    = 8'b1000_0000;
   localparam logic [7:0] INSTR_SET_DDRAM    = 8'h80;
   localparam logic [7:0] INSTR_SET_CGRAM    = 8'h40;
   localparam logic [7:0] GLYPH_ROW_MASK     = 8'b0001_1111;

   // Timing in units of 10 instruction cycles
   localparam logic [3:0]  HI_EN         = 4'd8;
   localparam logic [13:0] HI_WAIT       = 14'd8;
   localparam logic [3:0]  LO_EN         = 4'd7;
   localparam logic [13:0] LO_WAIT       = 14'd22;
   localparam logic [3:0]  WAKE_EN       = 4'd3;
   localparam logic [13:0] WAKE_WAIT     = 14'd3003;
   localparam logic [13:0] POWER_UP_WAIT = 14'd10000;
   localparam logic [13:0] SETUP_EXTRA   = 14'd3000;
   localparam logic [13:0] CLEAR_EXTRA   = 14'd1500;
   localparam logic [3:0]  WAKE_NIB_8BIT = 4'h3;
   localparam logic [3:0]  WAKE_NIB_4BIT = 4'h2;

   // Sequencer step numbers
   localparam logic [4:0] INIT_LAST_STEP   = 5'd18;
   localparam logic [4:0] INIT_WAKE_LAST   = 5'd3;
   localparam logic [4:0] INIT_4BIT_STEP   = 5'd4;
   localparam logic [4:0] INIT_SETUP_FIRST = 5'd5;
   localparam logic [4:0] INIT_SETUP_LAST  = 5'd14;
   localparam logic [4:0] INIT_CLEAR_FIRST = 5'd15;
   localparam logic [4:0] CLEAR_LAST_STEP  = 5'd3;
   localparam logic [4:0] ONE_LAST_STEP    = 5'd1;
   localparam logic [4:0] TWO_LAST_STEP    = 5'd3;

   typedef enum logic [1:0] {
      JOB_INIT,
      JOB_CLEAR,
      JOB_ONE_BYTE,
      JOB_TWO_BYTES
   } job_kind_type;

   // Classified command handed from front to back
   typedef struct packed {
      job_kind_type kind;
      logic         rs0;
      logic [7:0]   byte0;
      logic         rs1;
      logic [7:0]   byte1;
      logic [5:0]   cursor_col;
      logic         cursor_line;
   } job_type;

   // One bus strobe or wait item
   typedef struct packed {
      logic        strobe_res;
      logic        rs;
      logic [3:0]  nibble;
      logic [3:0]  enable_units;
      logic [13:0] wait_units;
      logic        last;
      logic [5:0]  cursor_col;
      logic        cursor_line;
   } item_type;

   // One half of a byte: high nibble first, low nibble carries the settle time
   function automatic item_type byte_item(logic rs, logic [7:0] b, logic lo,
                                          logic [13:0] extra);
      item_type it;
      it              = '0;
      it.strobe_res   = 1'b1;
      it.rs           = rs;
      it.nibble       = lo ? b[3:0] : b[7:4];
      it.enable_units = lo ? LO_EN : HI_EN;
      it.wait_units   = lo ? LO_WAIT + extra : HI_WAIT;
      return it;
   endfunction

   function automatic logic [7:0] setup_byte(logic [2:0] idx);
      logic [7:0] b;
      unique case (idx)
         3'd0:    b = INSTR_FUNCTION_SET;
         3'd1:    b = INSTR_DISPLAY_OFF;
         3'd2:    b = INSTR_CLEAR;
         3'd3:    b = INSTR_CURSOR_LINE;
         default: b = INSTR_ENTRY_MODE;
      endcase
      return b;
   endfunction

   // Clear display, then home address; four nibbles
   function automatic item_type clear_item(logic [1:0] s);
      item_type it;
      if (s[1]) begin
         it = byte_item(1'b0, INSTR_HOME_ADDR, s[0], 14'd0);
      end else begin
         it = byte_item(1'b0, INSTR_CLEAR, s[0], CLEAR_EXTRA);
      end
      return it;
   endfunction

   function automatic logic [4:0] last_step(job_kind_type kind);
      logic [4:0] s;
      unique case (kind)
         JOB_INIT:      s = INIT_LAST_STEP;
         JOB_CLEAR:     s = CLEAR_LAST_STEP;
         JOB_ONE_BYTE:  s = ONE_LAST_STEP;
         JOB_TWO_BYTES: s = TWO_LAST_STEP;
         default:       s = ONE_LAST_STEP;
      endcase
      return s;
   endfunction

   // Item produced for a given job at a given step
   function automatic item_type make_item(job_type job, logic [4:0] step);
      item_type   it;
      logic [4:0] rel;
      rel = '0;
      unique case (job.kind)
         JOB_INIT: begin
            if (step == 5'd0) begin
               it            = '0;
               it.wait_units = POWER_UP_WAIT;
            end else if (step <= INIT_WAKE_LAST) begin
               it              = '0;
               it.strobe_res   = 1'b1;
               it.nibble       = WAKE_NIB_8BIT;
               it.enable_units = WAKE_EN;
               it.wait_units   = WAKE_WAIT;
            end else if (step == INIT_4BIT_STEP) begin
               it              = '0;
               it.strobe_res   = 1'b1;
               it.nibble       = WAKE_NIB_4BIT;
               it.enable_units = WAKE_EN;
               it.wait_units   = WAKE_WAIT;
            end else if (step <= INIT_SETUP_LAST) begin
               rel = step - INIT_SETUP_FIRST;
               it  = byte_item(1'b0, setup_byte(rel[3:1]), rel[0], SETUP_EXTRA);
            end else begin
               rel = step - INIT_CLEAR_FIRST;
               it  = clear_item(rel[1:0]);
            end
         end
         JOB_CLEAR:    it = clear_item(step[1:0]);
         JOB_ONE_BYTE: it = byte_item(job.rs0, job.byte0, step[0], 14'd0);
         default: begin
            if (step[1]) begin
               it = byte_item(job.rs1, job.byte1, step[0], 14'd0);
            end else begin
               it = byte_item(job.rs0, job.byte0, step[0], 14'd0);
            end
         end
      endcase
      it.last        = (step == last_step(job.kind));
      it.cursor_col  = job.cursor_col;
      it.cursor_line = job.cursor_line;
      return it;
   endfunction

endpackage

>>> rtl/char_lcd_nibble_sequencer.sv
// Top level of the character LCD 4-bit bus sequencer.
// Depends on clns_pkg, clns_front, clns_job_queue and clns_back.
//
// Each accepted command is turned into a list of 4-bit bus strobe items, delivered one
// per cycle on the result queue while the result buffer is not full: init gives 19 items,
// clear and glyph row 4, every other command 2; the last item of a command has rsp_last
// set and all items carry the tracked cursor after that command. The sequencer's step
// counter emits one item per cycle unless the result buffer is full, so a command holds
// the sequencer until its last item is emitted. A command is registered in the job queue
// and each item in the result buffer before it can be popped. Two commands can wait in
// the job queue and two items in the result buffer. Line base registers are written
// through the csr port, which is always ready; writes past the line one base are ignored.
module char_lcd_nibble_sequencer
   import clns_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [6:0]  csr_data,
   input  logic        push,
   output logic        full,
   input  logic [2:0]  req_command,
   input  logic [7:0]  req_char_byte,
   input  logic [5:0]  req_col,
   input  logic        req_line,
   input  logic        req_block_cursor,
   input  logic [2:0]  req_glyph_slot,
   input  logic [2:0]  req_glyph_line,
   input  logic [7:0]  req_glyph_bits,
   output logic        empty,
   input  logic        pop,
   output logic        rsp_strobe_res,
   output logic        rsp_rs,
   output logic [3:0]  rsp_nibble,
   output logic [3:0]  rsp_enable_units,
   output logic [13:0] rsp_wait_units,
   output logic        rsp_last,
   output logic [5:0]  rsp_cursor_col,
   output logic        rsp_cursor_line
);

   job_type  new_job;
   job_type  head_job;
   logic     accept;
   logic     queue_empty;
   logic     job_pop;
   item_type rsp_item;

   assign accept = push & ~full;

   // Front end: classify and track cursor
   clns_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .accept           (accept),
      .req_command      (req_command),
      .req_char_byte    (req_char_byte),
      .req_col          (req_col),
      .req_line         (req_line),
      .req_block_cursor (req_block_cursor),
      .req_glyph_slot   (req_glyph_slot),
      .req_glyph_line   (req_glyph_line),
      .req_glyph_bits   (req_glyph_bits),
      .job              (new_job)
   );

   // Job queue decouples front from sequencer
   clns_job_queue u_job_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (accept),
      .push_job (new_job),
      .full     (full),
      .pop      (job_pop),
      .empty    (queue_empty),
      .head     (head_job)
   );

   // Back end: strobe sequencer and result buffer
   clns_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (~queue_empty),
      .job       (head_job),
      .job_pop   (job_pop),
      .rsp_pop   (pop),
      .rsp_empty (empty),
      .rsp_item  (rsp_item)
   );

   assign rsp_strobe_res   = rsp_item.strobe_res;
   assign rsp_rs           = rsp_item.rs;
   assign rsp_nibble       = rsp_item.nibble;
   assign rsp_enable_units = rsp_item.enable_units;
   assign rsp_wait_units   = rsp_item.wait_units;
   assign rsp_last         = rsp_item.last;
   assign rsp_cursor_col   = rsp_item.cursor_col;
   assign rsp_cursor_line  = rsp_item.cursor_line;

endmodule

>>> rtl/clns_front.sv
// Front end: holds line base registers and tracked cursor, classifies each command into a job.
// Depends on clns_pkg.
module clns_front
   import clns_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [1:0] csr_index,
   input  logic [6:0] csr_data,
   input  logic       accept,
   input  logic [2:0] req_command,
   input  logic [7:0] req_char_byte,
   input  logic [5:0] req_col,
   input  logic       req_line,
   input  logic       req_block_cursor,
   input  logic [2:0] req_glyph_slot,
   input  logic [2:0] req_glyph_line,
   input  logic [7:0] req_glyph_bits,
   output job_type    job
);

   logic [6:0] line0_base_ff, line0_base_in;
   logic [6:0] line1_base_ff, line1_base_in;
   logic [5:0] tracked_col_ff, tracked_col_in;
   logic       tracked_line_ff, tracked_line_in;
   logic [6:0] base;
   logic [6:0] addr;
   logic       csr_write;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid & csr_ready;

   // Line base registers; indexes past the list are dropped
   always_comb begin
      line0_base_in = line0_base_ff;
      line1_base_in = line1_base_ff;
      if (csr_write && csr_index == CSR_LINE0_BASE) begin
         line0_base_in = csr_data;
      end
      if (csr_write && csr_index == CSR_LINE1_BASE) begin
         line1_base_in = csr_data;
      end
   end

   // Display address for goto, wraps mod 128
   assign base = req_line ? line1_base_ff : line0_base_ff;
   assign addr = 7'({1'b0, req_col} + base);

   // Tracked cursor follows goto tracked, clear and init
   always_comb begin
      tracked_col_in  = tracked_col_ff;
      tracked_line_in = tracked_line_ff;
      if (accept) begin
         if (req_command == CMD_GOTO_TRACKED) begin
            tracked_col_in  = req_col;
            tracked_line_in = req_line;
         end else if (req_command == CMD_INIT || req_command == CMD_CLEAR) begin
            tracked_col_in  = '0;
            tracked_line_in = 1'b0;
         end
      end
   end

   // Classify the command
   always_comb begin
      job             = '0;
      job.cursor_col  = tracked_col_in;
      job.cursor_line = tracked_line_in;
      unique case (req_command)
         CMD_INIT:  job.kind = JOB_INIT;
         CMD_CLEAR: job.kind = JOB_CLEAR;
         CMD_WRITE_CHAR: begin
            job.kind  = JOB_ONE_BYTE;
            job.rs0   = 1'b1;
            job.byte0 = req_char_byte;
         end
         CMD_GOTO_TRACKED, CMD_GOTO_UNTRACKED: begin
            job.kind  = JOB_ONE_BYTE;
            job.byte0 = INSTR_SET_DDRAM | {1'b0, addr};
         end
         CMD_CURSOR_ON: begin
            job.kind  = JOB_ONE_BYTE;
            job.byte0 = req_block_cursor ? INSTR_CURSOR_BLOCK : INSTR_CURSOR_LINE;
         end
         CMD_CURSOR_OFF: begin
            job.kind  = JOB_ONE_BYTE;
            job.byte0 = INSTR_CURSOR_OFF;
         end
         default: begin
            job.kind  = JOB_TWO_BYTES;
            job.byte0 = INSTR_SET_CGRAM | {2'b00, req_glyph_slot, req_glyph_line};
            job.rs1   = 1'b1;
            job.byte1 = req_glyph_bits & GLYPH_ROW_MASK;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line0_base_ff   <= LINE0_BASE_RESET;
         line1_base_ff   <= LINE1_BASE_RESET;
         tracked_col_ff  <= '0;
         tracked_line_ff <= 1'b0;
      end else begin
         line0_base_ff   <= line0_base_in;
         line1_base_ff   <= line1_base_in;
         tracked_col_ff  <= tracked_col_in;
         tracked_line_ff <= tracked_line_in;
      end
   end

endmodule

>>> rtl/clns_job_queue.sv
// Two-entry queue of classified jobs between front end and sequencer.
// Depends on clns_pkg.
module clns_job_queue
   import clns_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   output logic    full,
   input  logic    pop,
   output logic    empty,
   output job_type head
);

   job_type    entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign full    = (count_ff == 2'd2);
   assign empty   = (count_ff == 2'd0);
   assign head    = entry_ff[rd_ptr_ff];
   assign do_push = push & ~full;
   assign do_pop  = pop & ~empty;

   // Pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

>>> rtl/clns_back.sv
// Back end: steps a job into a two-entry result buffer, one strobe item per cycle unless it is full.
// Depends on clns_pkg.
module clns_back
   import clns_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     job_valid,
   input  job_type  job,
   output logic     job_pop,
   input  logic     rsp_pop,
   output logic     rsp_empty,
   output item_type rsp_item
);

   item_type   buf_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic [4:0] step_ff, step_in;
   item_type   item_next;
   logic       emit;
   logic       take;

   // Generate the item for the current step
   assign item_next = make_item(job, step_ff);
   assign emit      = job_valid && (count_ff != 2'd2);
   assign job_pop   = emit && item_next.last;
   assign take      = rsp_pop && (count_ff != 2'd0);

   // Step counter walks the job's item list
   always_comb begin
      step_in = step_ff;
      if (emit) begin
         step_in = item_next.last ? 5'd0 : step_ff + 5'd1;
      end
   end

   // Result buffer bookkeeping
   always_comb begin
      wr_ptr_in = emit ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = take ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(emit) - 2'(take);
   end

   assign rsp_empty = (count_ff == 2'd0);
   assign rsp_item  = buf_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff   <= '0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         step_ff   <= step_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         buf_ff[wr_ptr_ff] <= item_next;
      end
   end

   // Step never runs past the longest sequence
   a_step_range: assert property (@(posedge clock) disable iff (reset)
      step_ff <= INIT_LAST_STEP)
      else $error("sequencer step out of range");

   // Final item of a job restarts the step counter
   a_last_restart: assert property (@(posedge clock) disable iff (reset)
      emit && item_next.last |=> step_ff == 5'd0)
      else $error("step not restarted after last item");

   // Buffer never overfills
   a_buf_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 2'd2)
      else $error("result buffer overflow");

   // A job is only released on its last item
   a_pop_on_last: assert property (@(posedge clock) disable iff (reset)
      job_pop |-> emit && item_next.last)
      else $error("job released early");

endmodule
